// ----- hdl/pulse_distance_bit_transmitter_top_defines.svh -----
// ----------------------------------------------------------------------------
// pulse distance transmitter assertion macros
// assertion forms for the transmitter core
// ----------------------------------------------------------------------------
`ifndef PULSE_DISTANCE_BIT_TRANSMITTER_TOP_DEFINES_SVH
`define PULSE_DISTANCE_BIT_TRANSMITTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PDBT_ASSERT_NOW(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_b)) else $error(msg);

// next-cycle implication, checked outside reset
`define PDBT_ASSERT_NEXT(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |=> (cond_b)) else $error(msg);

`endif

// ----- hdl/pdbt_pkg.sv -----
// ----------------------------------------------------------------------------
// pdbt_pkg
// types and constants for the pulse distance transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package pdbt_pkg;

    localparam int REG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int BIT_W   = 3;

    localparam logic [IDX_W-1:0] REG_SYNC_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] REG_ONE_PERIOD  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ZERO_PERIOD = 2'd2;
    localparam logic [IDX_W-1:0] REG_PULSE_WIDTH = 2'd3;

    localparam logic [REG_W-1:0] RST_SYNC_PERIOD = 16'd5000;
    localparam logic [REG_W-1:0] RST_ONE_PERIOD  = 16'd2000;
    localparam logic [REG_W-1:0] RST_ZERO_PERIOD = 16'd1000;
    localparam logic [REG_W-1:0] RST_PULSE_WIDTH = 16'd50;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    localparam logic [BIT_W-1:0] BIT_MSB  = 3'd7;
    localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

    typedef struct packed {
        logic [REG_W-1:0] sync_period;
        logic [REG_W-1:0] one_period;
        logic [REG_W-1:0] zero_period;
        logic [REG_W-1:0] pulse_width;
    } t_cfg;

    // pin_level ends up in bit 0
    typedef struct packed {
        logic load_rejected;
        logic busy_res;
        logic period_start;
        logic pin_level;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int OUT_W    = 8;

endpackage

`default_nettype wire

// ----- hdl/pulse_distance_bit_transmitter_top.sv -----
// the result beat of an accepted input beat is registered for the next cycle
// throughput: one beat per cycle, ticks and loads alike, while the result
// register is empty or taken; the period timer, bit sequencer and buffer
// prefetch update per beat; the result register frees when its beat is taken
// reset (synchronous, active low) clears sequencer, timer and registers;
// the message buffer is not cleared, only bytes loaded for a message are read
// ----------------------------------------------------------------------------
// pulse_distance_bit_transmitter_top
// pulse distance transmitter with message buffer and stream ports
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_distance_bit_transmitter_top #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // data_byte
    input  wire logic                        s_axis_tlast,   // last_byte
    input  wire logic                        s_axis_tuser,   // func
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // pin_level, period_start, busy_res, load_rejected, zero fill
    output logic [7:0]                       m_axis_tdata,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [pdbt_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [pdbt_pkg::REG_W-1:0]  i_cfg_data
);

    pdbt_pkg::t_cfg    cfg;
    pdbt_pkg::t_result result;
    logic              accept;
    logic              r_out_valid;
    pdbt_pkg::t_result r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pdbt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pdbt_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_func      (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(pdbt_pkg::OUT_W - pdbt_pkg::RESULT_W)'(0), r_out_data};

endmodule

`default_nettype wire

// ----- hdl/pdbt_ram.sv -----
// ----------------------------------------------------------------------------
// pdbt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pdbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/pdbt_cfg.sv -----
// ----------------------------------------------------------------------------
// pdbt_cfg
// period and pulse width registers behind a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module pdbt_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [pdbt_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [pdbt_pkg::REG_W-1:0]  i_cfg_data,
    output pdbt_pkg::t_cfg                   o_cfg
);

    pdbt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_period <= pdbt_pkg::RST_SYNC_PERIOD;
            r_cfg.one_period  <= pdbt_pkg::RST_ONE_PERIOD;
            r_cfg.zero_period <= pdbt_pkg::RST_ZERO_PERIOD;
            r_cfg.pulse_width <= pdbt_pkg::RST_PULSE_WIDTH;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pdbt_pkg::REG_SYNC_PERIOD: r_cfg.sync_period <= i_cfg_data;
                pdbt_pkg::REG_ONE_PERIOD:  r_cfg.one_period  <= i_cfg_data;
                pdbt_pkg::REG_ZERO_PERIOD: r_cfg.zero_period <= i_cfg_data;
                pdbt_pkg::REG_PULSE_WIDTH: r_cfg.pulse_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/pdbt_core.sv -----
// ----------------------------------------------------------------------------
// pdbt_core
// message buffer, period timer and bit sequencer, one beat per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pdbt_core #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_func,
    input  wire logic [pdbt_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                         i_last_byte,
    input  wire pdbt_pkg::t_cfg               i_cfg,
    output pdbt_pkg::t_result                 o_result
);

    `include "pulse_distance_bit_transmitter_top_defines.svh"

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int CW = FW + 1;
    localparam int PW = pdbt_pkg::REG_W + 1;

    logic [FW-1:0]                r_fill,     n_fill;
    logic [AW-1:0]                r_byte_pos, n_byte_pos;
    logic [pdbt_pkg::BIT_W-1:0]   r_bit_pos,  n_bit_pos;
    logic                         r_sending,  n_sending;
    logic [pdbt_pkg::REG_W-1:0]   r_tick,     n_tick;
    logic [pdbt_pkg::REG_W-1:0]   r_period,   n_period;
    logic [pdbt_pkg::BYTE_W-1:0]  r_cur_byte, n_cur_byte;
    logic                         r_byp_hit;
    logic [pdbt_pkg::BYTE_W-1:0]  r_byp_data;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [pdbt_pkg::BYTE_W-1:0]  ram_q;
    logic [pdbt_pkg::BYTE_W-1:0]  next_byte;
    logic                         is_load;
    logic                         is_tick;
    logic                         full;
    logic                         reject;
    logic                         period_end;
    logic                         cur_bit;
    logic [CW-1:0]                byte_inc;

    assign is_load    = i_en && (i_func == pdbt_pkg::FUNC_LOAD);
    assign is_tick    = i_en && (i_func == pdbt_pkg::FUNC_TICK);
    assign full       = r_fill >= FW'(BUFFER_BYTES);
    assign reject     = is_load && (r_sending || full);
    assign wr_en      = is_load && !reject;
    assign wr_addr    = AW'(r_fill);
    assign period_end = (PW'(r_tick) + PW'(1)) >= PW'(r_period);
    assign cur_bit    = r_cur_byte[pdbt_pkg::BIT_MSB - r_bit_pos];
    assign byte_inc   = CW'(r_byte_pos) + CW'(1);
    assign next_byte  = r_byp_hit ? r_byp_data : ram_q;
    assign rd_addr    = n_byte_pos + AW'(1);

    always_comb begin
        n_fill     = r_fill;
        n_byte_pos = r_byte_pos;
        n_bit_pos  = r_bit_pos;
        n_sending  = r_sending;
        n_tick     = r_tick;
        n_period   = r_period;
        n_cur_byte = r_cur_byte;
        if (wr_en) begin
            n_fill = r_fill + FW'(1);
            if (r_fill == '0) begin
                n_cur_byte = i_data_byte;
            end
            if (i_last_byte) begin
                n_sending  = 1'b1;
                n_byte_pos = '0;
                n_bit_pos  = '0;
            end
        end
        if (is_tick) begin
            if (period_end) begin
                n_tick = '0;
                if (!r_sending) begin
                    n_period = i_cfg.sync_period;
                end else begin
                    n_period  = cur_bit ? i_cfg.one_period : i_cfg.zero_period;
                    n_bit_pos = r_bit_pos + pdbt_pkg::BIT_W'(1);
                    if (r_bit_pos == pdbt_pkg::BIT_LAST) begin
                        n_byte_pos = AW'(byte_inc);
                        n_cur_byte = next_byte;
                        if (byte_inc >= CW'(r_fill)) begin
                            n_sending  = 1'b0;
                            n_byte_pos = '0;
                            n_fill     = '0;
                        end
                    end
                end
            end else begin
                n_tick = r_tick + pdbt_pkg::REG_W'(1);
            end
        end
    end

    always_comb begin
        o_result.pin_level     = r_tick < i_cfg.pulse_width;
        o_result.period_start  = is_tick && (r_tick == '0);
        o_result.busy_res      = n_sending;
        o_result.load_rejected = reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_byte_pos <= '0;
            r_bit_pos  <= '0;
            r_sending  <= 1'b0;
            r_tick     <= '0;
            r_period   <= pdbt_pkg::RST_SYNC_PERIOD;
            r_byp_hit  <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_byte_pos <= n_byte_pos;
            r_bit_pos  <= n_bit_pos;
            r_sending  <= n_sending;
            r_tick     <= n_tick;
            r_period   <= n_period;
            r_byp_hit  <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_byte <= n_cur_byte;
        r_byp_data <= i_data_byte;
    end

    // read port prefetches the byte after the one being sent
    pdbt_ram #(
        .WIDTH (pdbt_pkg::BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_data_byte),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    `PDBT_ASSERT_NOW(a_send_has_bytes, r_sending, r_fill != '0, "sending with empty buffer")
    `PDBT_ASSERT_NOW(a_idle_pos_clear, !r_sending,
        (r_byte_pos == '0) && (r_bit_pos == '0), "position not cleared while idle")
    `PDBT_ASSERT_NOW(a_tick_in_period, 1'b1,
        (r_tick == '0) || (r_tick < r_period), "tick count beyond period")
    `PDBT_ASSERT_NEXT(a_last_starts, wr_en && i_last_byte, r_sending,
        "accepted last byte did not start sending")

endmodule

`default_nettype wire
